// ===== rtl/core/hmfc_pkg.sv =====
// hmfc_pkg: shared types, codes and constants for the heater mode and fault controller
// used by every module under rtl/core; no dependencies of its own
`default_nettype none

package hmfc_pkg;

  localparam int unsigned TimeWidth = 16;
  localparam logic [TimeWidth-1:0] TimeMax = '1;
  localparam logic [TimeWidth-1:0] LimitReset = 16'd60;

  typedef enum logic [1:0] {
    MODE_POWER_ON = 2'd0,
    MODE_READY    = 2'd1,
    MODE_RUN      = 2'd2,
    MODE_ALARM    = 2'd3
  } mode_t;

  localparam logic [1:0] KeyNone  = 2'd0;
  localparam logic [1:0] KeyShort = 2'd1;
  localparam logic [1:0] KeyLong  = 2'd2;

  localparam logic [1:0] Level40 = 2'd0;
  localparam logic [1:0] Level50 = 2'd1;
  localparam logic [1:0] Level60 = 2'd2;

  localparam logic [2:0] ErrNone       = 3'd0;
  localparam logic [2:0] ErrShort      = 3'd1;
  localparam logic [2:0] ErrNoLoad     = 3'd2;
  localparam logic [2:0] ErrTriacShort = 3'd3;
  localparam logic [2:0] ErrNoZero     = 3'd4;

  // lamp vector: bit 0 yellow, bit 1 orange, bit 2 red
  localparam logic [2:0] LampOff    = 3'b000;
  localparam logic [2:0] LampYellow = 3'b001;
  localparam logic [2:0] LampOrange = 3'b010;
  localparam logic [2:0] LampRed    = 3'b100;
  localparam logic [2:0] LampAll    = 3'b111;

  typedef struct packed {
    logic       fault_short;
    logic       fault_no_load;
    logic       fault_triac_short;
    logic       fault_no_zero_cross;
    logic [1:0] key_event;
    logic       one_second_flag;
    logic       half_second_tick;
    logic       time_tick;
  } event_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] heat_level;
    logic [2:0] error_code;
    logic [2:0] lamps;
    logic       heater_enable;
    logic       fuse_blow;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/hmfc_in_stage.sv =====
// hmfc_in_stage: input register for one control event word
// depends on hmfc_pkg for the event type
`default_nettype none

module hmfc_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic            advance,
  input  wire hmfc_pkg::event_t ev_in,
  output logic                 full,
  output hmfc_pkg::event_t     ev
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev <= ev_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hmfc_update.sv =====
// hmfc_update: controller state, run time limit register and the per-word update logic
// depends on hmfc_pkg for mode, codes and the event and result types
`default_nettype none

module hmfc_update (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [hmfc_pkg::TimeWidth-1:0] cfg_wr_data,
  input  wire logic                           advance,
  input  wire hmfc_pkg::event_t               ev,
  output hmfc_pkg::result_t                   result_next
);

  hmfc_pkg::mode_t                 mode;
  hmfc_pkg::mode_t                 mode_next;
  hmfc_pkg::mode_t                 mode_chk;
  logic [1:0]                      level;
  logic [1:0]                      level_next;
  logic [2:0]                      error;
  logic [2:0]                      error_next;
  logic [2:0]                      lamps;
  logic [2:0]                      lamps_next;
  logic [hmfc_pkg::TimeWidth-1:0]  elapsed;
  logic [hmfc_pkg::TimeWidth-1:0]  elapsed_next;
  logic [hmfc_pkg::TimeWidth-1:0]  elapsed_tick;
  logic [hmfc_pkg::TimeWidth-1:0]  elapsed_key;
  logic [hmfc_pkg::TimeWidth-1:0]  limit;
  logic                            fuse;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= hmfc_pkg::LimitReset;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= hmfc_pkg::MODE_POWER_ON;
      level   <= hmfc_pkg::Level40;
      error   <= hmfc_pkg::ErrNone;
      lamps   <= hmfc_pkg::LampOff;
      elapsed <= '0;
    end else if (advance) begin
      mode    <= mode_next;
      level   <= level_next;
      error   <= error_next;
      lamps   <= lamps_next;
      elapsed <= elapsed_next;
    end
  end

  // saturating tick, then fault latch in priority order
  always_comb begin
    elapsed_tick = elapsed;
    if (ev.time_tick && (elapsed != hmfc_pkg::TimeMax)) begin
      elapsed_tick = elapsed + 1'b1;
    end
    mode_chk   = mode;
    error_next = error;
    if (mode != hmfc_pkg::MODE_ALARM) begin
      if (ev.fault_short) begin
        mode_chk   = hmfc_pkg::MODE_ALARM;
        error_next = hmfc_pkg::ErrShort;
      end else if (ev.fault_no_load) begin
        mode_chk   = hmfc_pkg::MODE_ALARM;
        error_next = hmfc_pkg::ErrNoLoad;
      end else if (ev.fault_triac_short) begin
        mode_chk   = hmfc_pkg::MODE_ALARM;
        error_next = hmfc_pkg::ErrTriacShort;
      end else if (ev.fault_no_zero_cross) begin
        mode_chk   = hmfc_pkg::MODE_ALARM;
        error_next = hmfc_pkg::ErrNoZero;
      end
    end
  end

  // next mode, level and elapsed time
  always_comb begin
    mode_next    = mode_chk;
    level_next   = level;
    elapsed_key  = elapsed_tick;
    elapsed_next = elapsed_tick;
    unique case (mode_chk)
      hmfc_pkg::MODE_POWER_ON: begin
        if (ev.one_second_flag) begin
          mode_next = hmfc_pkg::MODE_READY;
        end
      end
      hmfc_pkg::MODE_READY: begin
        if (ev.key_event == hmfc_pkg::KeyShort) begin
          level_next   = hmfc_pkg::Level40;
          mode_next    = hmfc_pkg::MODE_RUN;
          elapsed_next = '0;
        end
      end
      hmfc_pkg::MODE_RUN: begin
        if (ev.key_event == hmfc_pkg::KeyShort) begin
          level_next  = (level == hmfc_pkg::Level40) ? hmfc_pkg::Level50 :
                        (level == hmfc_pkg::Level50) ? hmfc_pkg::Level60 :
                                                       hmfc_pkg::Level40;
          elapsed_key = '0;
        end
        elapsed_next = elapsed_key;
        if (elapsed_key >= limit) begin
          elapsed_next = '0;
          mode_next    = hmfc_pkg::MODE_READY;
        end
        if (ev.key_event == hmfc_pkg::KeyLong) begin
          mode_next = hmfc_pkg::MODE_READY;
        end
      end
      hmfc_pkg::MODE_ALARM: begin
        mode_next = hmfc_pkg::MODE_ALARM;
      end
      default: begin
        mode_next = mode_chk;
      end
    endcase
  end

  // lamps and fuse pulse
  always_comb begin
    lamps_next = lamps;
    fuse       = 1'b0;
    unique case (mode_chk)
      hmfc_pkg::MODE_POWER_ON: begin
        lamps_next = ev.one_second_flag ? hmfc_pkg::LampOff : hmfc_pkg::LampAll;
      end
      hmfc_pkg::MODE_READY: begin
        lamps_next = hmfc_pkg::LampOff;
      end
      hmfc_pkg::MODE_RUN: begin
        case (level)
          hmfc_pkg::Level40: lamps_next = hmfc_pkg::LampYellow;
          hmfc_pkg::Level50: lamps_next = hmfc_pkg::LampOrange;
          hmfc_pkg::Level60: lamps_next = hmfc_pkg::LampRed;
          default:           lamps_next = lamps;
        endcase
      end
      hmfc_pkg::MODE_ALARM: begin
        if (ev.half_second_tick) begin
          case (error_next)
            hmfc_pkg::ErrShort:  lamps_next = lamps ^ hmfc_pkg::LampRed;
            hmfc_pkg::ErrNoLoad: lamps_next = lamps ^ hmfc_pkg::LampOrange;
            hmfc_pkg::ErrTriacShort: begin
              lamps_next = lamps ^ (hmfc_pkg::LampRed | hmfc_pkg::LampOrange);
              fuse       = 1'b1;
            end
            hmfc_pkg::ErrNoZero: lamps_next = lamps ^ hmfc_pkg::LampAll;
            default:             lamps_next = lamps;
          endcase
        end
      end
      default: begin
        lamps_next = lamps;
      end
    endcase
  end

  always_comb begin
    result_next.mode          = mode_next;
    result_next.heat_level    = level_next;
    result_next.error_code    = error_next;
    result_next.lamps         = lamps_next;
    result_next.heater_enable = (mode_next == hmfc_pkg::MODE_RUN);
    result_next.fuse_blow     = fuse;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hmfc_out_stage.sv =====
// hmfc_out_stage: result register holding one result word until it is taken
// depends on hmfc_pkg for the result type
`default_nettype none

module hmfc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              out_stall,
  input  wire hmfc_pkg::result_t result_next,
  output logic                   full,
  output hmfc_pkg::result_t      result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (advance) begin
      full <= 1'b1;
    end else if (!out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/heater_mode_and_fault_controller_top.sv =====
// heater_mode_and_fault_controller_top: heater mode and fault controller, top level
// instantiates hmfc_in_stage, hmfc_update and hmfc_out_stage; uses hmfc_pkg
// a word accepted into the input register passes through hmfc_update into the result register
// throughput: one word per cycle, limited only by stall on the result side
// the input register and result register each hold one word
// reset (rst, synchronous): power-on mode, level 0, no error, lamps off,
// elapsed time 0, run time limit 60
`default_nettype none

module heater_mode_and_fault_controller_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        fault_short,
  input  wire logic        fault_no_load,
  input  wire logic        fault_triac_short,
  input  wire logic        fault_no_zero_cross,
  input  wire logic [1:0]  key_event,
  input  wire logic        one_second_flag,
  input  wire logic        half_second_tick,
  input  wire logic        time_tick,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       mode,
  output logic [1:0]       heat_level,
  output logic [2:0]       error_code,
  output logic             led_yellow,
  output logic             led_orange,
  output logic             led_red,
  output logic             heater_enable,
  output logic             fuse_blow
);

  hmfc_pkg::event_t  ev_in;
  hmfc_pkg::event_t  ev;
  hmfc_pkg::result_t result_next;
  hmfc_pkg::result_t result;
  logic              in_full;
  logic              load;
  logic              advance;

  assign ev_in.fault_short         = fault_short;
  assign ev_in.fault_no_load       = fault_no_load;
  assign ev_in.fault_triac_short   = fault_triac_short;
  assign ev_in.fault_no_zero_cross = fault_no_zero_cross;
  assign ev_in.key_event           = key_event;
  assign ev_in.one_second_flag     = one_second_flag;
  assign ev_in.half_second_tick    = half_second_tick;
  assign ev_in.time_tick           = time_tick;

  // the held word moves on whenever the result register is free or being emptied
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign load     = in_valid && !in_stall;

  hmfc_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .advance (advance),
    .ev_in   (ev_in),
    .full    (in_full),
    .ev      (ev)
  );

  hmfc_update u_update (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .ev          (ev),
    .result_next (result_next)
  );

  hmfc_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .out_stall   (out_stall),
    .result_next (result_next),
    .full        (out_valid),
    .result      (result)
  );

  assign mode          = result.mode;
  assign heat_level    = result.heat_level;
  assign error_code    = result.error_code;
  assign led_yellow    = result.lamps[0];
  assign led_orange    = result.lamps[1];
  assign led_red       = result.lamps[2];
  assign heater_enable = result.heater_enable;
  assign fuse_blow     = result.fuse_blow;

endmodule

`default_nettype wire
